### src/dwps_pkg.sv
// Shared types and constants for the daily window power scheduler.
`timescale 1ns / 1ps

package dwps_pkg;

    localparam int CHANNELS  = 3;
    localparam int CH_W      = 2;
    localparam int MIN_W     = 11;
    localparam int EPOCH_W   = 32;
    localparam int TOD_W     = 17;
    localparam int DELTA_W   = 19;
    localparam int CFG_IDX_W = 3;

    localparam logic [DELTA_W-1:0] DAY_SECONDS = DELTA_W'(86400);
    localparam logic [TOD_W-1:0]   SEC_PER_HOUR = TOD_W'(3600);
    localparam logic [TOD_W-1:0]   SEC_PER_MIN  = TOD_W'(60);
    localparam logic [CHANNELS-1:0] HOLD_MASK_RESET = CHANNELS'(3);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CH0_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH0_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_OFF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK = 3'd6;

    typedef enum logic [1:0] {
        DRIVE_ON   = 2'd0,
        DRIVE_OFF  = 2'd1,
        DRIVE_HOLD = 2'd2
    } t_drive;

    // window settings of the channel under evaluation
    typedef struct packed {
        logic [MIN_W-1:0] on_min;
        logic [MIN_W-1:0] off_min;
        logic             hold;
    } t_chan_cfg;

endpackage

### src/daily_window_power_scheduler_unit.sv
// Top level of the daily window power scheduler: sequencer, state and output stage.
//
//   channel   direction   handshake                    payload
//   in        request in  i_in_valid / o_in_ready      i_cmd, i_now_epoch, i_now_hour,
//                                                      i_now_minute, i_now_second
//   out       result out  o_out_valid / i_out_ready    o_channel, o_drive, o_next_time,
//                                                      o_earliest_channel, o_earliest_time,
//                                                      o_last
//   cfg       write only  i_cfg_we                     i_cfg_index, i_cfg_data
//
// A start request is accepted, then each channel is evaluated and emitted in turn, with a pick
// step before the final result; a trigger request evaluates only the stored earliest channel.
// The single evaluation unit handles one channel at a time.
// Reset is synchronous and active low; it clears the schedule and the window times and loads HOLD_MASK_RESET.
// A stalled result sits in the output register; the sequencer waits in its emit step
// and the block takes the next request as soon as the final result is loaded.
`timescale 1ns / 1ps

module daily_window_power_scheduler_unit
    import dwps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [EPOCH_W-1:0]   i_now_epoch,
    input  logic [4:0]           i_now_hour,
    input  logic [5:0]           i_now_minute,
    input  logic [5:0]           i_now_second,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CH_W-1:0]      o_channel,
    output logic [1:0]           o_drive,
    output logic [EPOCH_W-1:0]   o_next_time,
    output logic [CH_W-1:0]      o_earliest_channel,
    output logic [EPOCH_W-1:0]   o_earliest_time,
    output logic                 o_last,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MIN_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_PICK = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state;
    logic               r_trigger;
    logic [EPOCH_W-1:0] r_epoch;
    logic [TOD_W-1:0]   r_tod;
    logic [CH_W-1:0]    r_ch;
    logic [CH_W-1:0]    r_last_ch;
    logic [EPOCH_W-1:0] r_next [CHANNELS];
    logic [CH_W-1:0]    r_earliest_index;

    // pending result, built by the evaluate and pick steps
    logic [CH_W-1:0]    r_res_ch;
    t_drive             r_res_drive;
    logic [EPOCH_W-1:0] r_res_next;
    logic               r_res_last;
    logic [CH_W-1:0]    r_res_ech;
    logic [EPOCH_W-1:0] r_res_etime;

    // output register
    logic               r_o_valid;
    logic [CH_W-1:0]    r_o_channel;
    t_drive             r_o_drive;
    logic [EPOCH_W-1:0] r_o_next;
    logic [CH_W-1:0]    r_o_ech;
    logic [EPOCH_W-1:0] r_o_etime;
    logic               r_o_last;

    logic [TOD_W-1:0]   n_tod;
    logic [CH_W-1:0]    n_start_ch;
    logic [CH_W-1:0]    n_pick;
    logic [EPOCH_W-1:0] n_pick_time;
    logic               pick01;
    logic [EPOCH_W-1:0] next01;
    logic               out_free;

    t_chan_cfg          chan_cfg;
    t_drive             ev_drive;
    logic [EPOCH_W-1:0] ev_next;

    dwps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sel_ch    (r_ch),
        .o_chan_cfg  (chan_cfg)
    );

    dwps_eval u_eval (
        .i_chan_cfg (chan_cfg),
        .i_tod      (r_tod),
        .i_epoch    (r_epoch),
        .i_starting (!r_trigger),
        .o_drive    (ev_drive),
        .o_next     (ev_next)
    );

    // time of day in seconds; constant multipliers only
    assign n_tod = TOD_W'(i_now_hour) * SEC_PER_HOUR
                 + TOD_W'(i_now_minute) * SEC_PER_MIN
                 + TOD_W'(i_now_second);

    // trigger evaluates the stored earliest channel, folded into range
    assign n_start_ch = (r_earliest_index >= CH_W'(CHANNELS)) ? '0 : r_earliest_index;

    // earliest stored switch: lowest index wins ties
    assign pick01 = (r_next[1] < r_next[0]);
    assign next01 = pick01 ? r_next[1] : r_next[0];

    always_comb begin
        if (r_next[2] < next01) begin
            n_pick      = CH_W'(2);
            n_pick_time = r_next[2];
        end else begin
            n_pick      = CH_W'(pick01);
            n_pick_time = next01;
        end
    end

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_o_valid        <= 1'b0;
            r_earliest_index <= '0;
            r_ch             <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_next[i] <= '0;
            end
        end else begin
            // load the output when the emit step has room; drop it once taken
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_trigger <= i_cmd;
                        r_epoch   <= i_now_epoch;
                        r_tod     <= n_tod;
                        r_ch      <= i_cmd ? n_start_ch : '0;
                        r_last_ch <= i_cmd ? n_start_ch : CH_W'(CHANNELS - 1);
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (r_ch == CH_W'(i)) begin
                            r_next[i] <= ev_next;
                        end
                    end
                    r_res_ch    <= r_ch;
                    r_res_drive <= ev_drive;
                    r_res_next  <= ev_next;
                    r_res_last  <= (r_ch == r_last_ch);
                    r_res_ech   <= '0;
                    r_res_etime <= '0;
                    r_state     <= (r_ch == r_last_ch) ? S_PICK : S_OUT;
                end
                S_PICK: begin
                    r_earliest_index <= n_pick;
                    r_res_ech        <= n_pick;
                    r_res_etime      <= n_pick_time;
                    r_state          <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_channel <= r_res_ch;
                        r_o_drive   <= r_res_drive;
                        r_o_next    <= r_res_next;
                        r_o_ech     <= r_res_ech;
                        r_o_etime   <= r_res_etime;
                        r_o_last    <= r_res_last;
                        if (r_res_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_EVAL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_channel          = r_o_channel;
    assign o_drive            = r_o_drive;
    assign o_next_time        = r_o_next;
    assign o_earliest_channel = r_o_ech;
    assign o_earliest_time    = r_o_etime;
    assign o_last             = r_o_last;

`ifndef ASSERT_OFF
    // summary fields stay zero on every result but the final one
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_earliest_time == '0 && o_earliest_channel == '0))
        else $error("summary fields set on a non-final result");

    // the stored earliest channel always names a real channel
    a_earliest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_earliest_index < CH_W'(CHANNELS))
        else $error("earliest index out of range");

    // a result never names a channel that does not exist
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_channel < CH_W'(CHANNELS)))
        else $error("result channel out of range");

    // an accepted request starts evaluation in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("accepted request did not start evaluation");
`endif

endmodule

### src/dwps_cfg.sv
// Configuration registers and per-channel window select.
`timescale 1ns / 1ps

module dwps_cfg
    import dwps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MIN_W-1:0]     i_cfg_data,
    input  logic [CH_W-1:0]      i_sel_ch,
    output t_chan_cfg            o_chan_cfg
);

    logic [MIN_W-1:0]    r_on_min  [CHANNELS];
    logic [MIN_W-1:0]    r_off_min [CHANNELS];
    logic [CHANNELS-1:0] r_hold_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_on_min[i]  <= '0;
                r_off_min[i] <= '0;
            end
            r_hold_mask <= HOLD_MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CH0_ON:    r_on_min[0]  <= i_cfg_data;
                REG_CH0_OFF:   r_off_min[0] <= i_cfg_data;
                REG_CH1_ON:    r_on_min[1]  <= i_cfg_data;
                REG_CH1_OFF:   r_off_min[1] <= i_cfg_data;
                REG_CH2_ON:    r_on_min[2]  <= i_cfg_data;
                REG_CH2_OFF:   r_off_min[2] <= i_cfg_data;
                REG_HOLD_MASK: r_hold_mask  <= i_cfg_data[CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_chan_cfg = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_sel_ch == CH_W'(i)) begin
                o_chan_cfg.on_min  = r_on_min[i];
                o_chan_cfg.off_min = r_off_min[i];
                o_chan_cfg.hold    = r_hold_mask[i];
            end
        end
    end

endmodule

### src/dwps_eval.sv
// Window evaluation unit, shared by all channels: drive and next switch epoch.
`timescale 1ns / 1ps

module dwps_eval
    import dwps_pkg::*;
(
    input  t_chan_cfg            i_chan_cfg,
    input  logic [TOD_W-1:0]     i_tod,
    input  logic [EPOCH_W-1:0]   i_epoch,
    input  logic                 i_starting,
    output t_drive               o_drive,
    output logic [EPOCH_W-1:0]   o_next
);

    logic [DELTA_W-1:0] on_s;
    logic [DELTA_W-1:0] off_s;
    logic [DELTA_W-1:0] tod_s;
    logic [DELTA_W-1:0] delta;
    t_drive             drive;

    // minutes * 60 as (m << 6) - (m << 2)
    assign on_s  = (DELTA_W'(i_chan_cfg.on_min) << 6) - (DELTA_W'(i_chan_cfg.on_min) << 2);
    assign off_s = (DELTA_W'(i_chan_cfg.off_min) << 6) - (DELTA_W'(i_chan_cfg.off_min) << 2);
    assign tod_s = DELTA_W'(i_tod);

    always_comb begin
        drive = DRIVE_OFF;
        delta = '0;
        if (on_s < off_s) begin
            if (tod_s >= on_s && tod_s < off_s) begin
                drive = DRIVE_ON;
                delta = off_s - tod_s;
            end else if (tod_s < on_s) begin
                delta = on_s - tod_s;
            end else begin
                delta = on_s + DAY_SECONDS - tod_s;
            end
        end else if (on_s > off_s) begin
            if (tod_s >= on_s) begin
                drive = DRIVE_ON;
                delta = off_s + DAY_SECONDS - tod_s;
            end else if (tod_s < off_s) begin
                drive = DRIVE_ON;
                delta = off_s - tod_s;
            end else begin
                delta = on_s - tod_s;
            end
        end
        if (i_starting && drive == DRIVE_OFF && i_chan_cfg.hold) begin
            drive = DRIVE_HOLD;
        end
    end

    // delta may be negative for out-of-range times; sign-extend and wrap
    assign o_next  = i_epoch + {{(EPOCH_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    assign o_drive = drive;

endmodule
